[rtl/shs_pkg.sv]
`default_nettype none

package shs_pkg;

  // Input command codes
  localparam logic [1:0] CMD_DATA    = 2'd0;
  localparam logic [1:0] CMD_FINAL   = 2'd1;
  localparam logic [1:0] CMD_RESTART = 2'd2;
  localparam logic [1:0] CMD_NONE    = 2'd3;

  localparam logic [7:0] PAD_BYTE = 8'h80;
  localparam logic [6:0] LEN_POS  = 7'd56;
  localparam logic [6:0] BLK_LAST = 7'd63;
  localparam logic [6:0] BLK_FULL = 7'd64;

  typedef logic [31:0] word_t;
  // Eight working / chaining words, element 0 is word a (H0)
  typedef logic [7:0][31:0] hstate_t;

  // Control from the sequencer into the compression unit
  typedef struct packed {
    logic       load;      // shift one byte into the block window
    logic [7:0] byte_val;
    logic       start;     // begin 64 rounds from hash_in
  } cmp_ctl_t;

  localparam word_t IV [8] = '{
    32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
    32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19};

  localparam word_t RK [64] = '{
    32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5, 32'h3956c25b, 32'h59f111f1,
    32'h923f82a4, 32'hab1c5ed5, 32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
    32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174, 32'he49b69c1, 32'hefbe4786,
    32'h0fc19dc6, 32'h240ca1cc, 32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
    32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7, 32'hc6e00bf3, 32'hd5a79147,
    32'h06ca6351, 32'h14292967, 32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
    32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85, 32'ha2bfe8a1, 32'ha81a664b,
    32'hc24b8b70, 32'hc76c51a3, 32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
    32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5, 32'h391c0cb3, 32'h4ed8aa4a,
    32'h5b9cca4f, 32'h682e6ff3, 32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
    32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2};

  function automatic word_t big_sig0(input word_t x);
    return {x[1:0], x[31:2]} ^ {x[12:0], x[31:13]} ^ {x[21:0], x[31:22]};
  endfunction

  function automatic word_t big_sig1(input word_t x);
    return {x[5:0], x[31:6]} ^ {x[10:0], x[31:11]} ^ {x[24:0], x[31:25]};
  endfunction

  function automatic word_t small_sig0(input word_t x);
    return {x[6:0], x[31:7]} ^ {x[17:0], x[31:18]} ^ {3'b000, x[31:3]};
  endfunction

  function automatic word_t small_sig1(input word_t x);
    return {x[16:0], x[31:17]} ^ {x[18:0], x[31:19]} ^ {10'd0, x[31:10]};
  endfunction

endpackage

`default_nettype wire

[rtl/shs_compress.sv]
`default_nettype none

// Block window plus one SHA-256 round per cycle. The window is a 64-byte
// shift line; during the rounds it slides one word a cycle and holds
// W[t..t+15], the new word W[t+16] entering at the bottom.
module shs_compress (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire shs_pkg::cmp_ctl_t ctl,
  input  wire shs_pkg::hstate_t  hash_in,
  output shs_pkg::hstate_t       work,
  output logic                  done
);
  import shs_pkg::*;

  logic [511:0] win;
  logic         busy;
  logic [5:0]   round;

  word_t w0, w1, w9, w14, w_new, t1, t2;
  hstate_t work_next;

  assign w0  = win[511 -: 32];
  assign w1  = win[479 -: 32];
  assign w9  = win[223 -: 32];
  assign w14 = win[63 -: 32];

  always_comb begin
    w_new = small_sig1(w14) + w9 + small_sig0(w1) + w0;
    t1 = work[7] + big_sig1(work[4]) + ((work[4] & work[5]) ^ (~work[4] & work[6]))
         + RK[round] + w0;
    t2 = big_sig0(work[0]) + ((work[0] & work[1]) ^ (work[0] & work[2]) ^ (work[1] & work[2]));
    work_next[0] = t1 + t2;
    work_next[1] = work[0];
    work_next[2] = work[1];
    work_next[3] = work[2];
    work_next[4] = work[3] + t1;
    work_next[5] = work[4];
    work_next[6] = work[5];
    work_next[7] = work[6];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy  <= 1'b0;
      done  <= 1'b0;
      round <= 6'd0;
    end else begin
      done <= busy && (round == 6'd63);
      if (ctl.start) begin
        busy  <= 1'b1;
        round <= 6'd0;
      end else if (busy) begin
        round <= round + 6'd1;
        if (round == 6'd63) begin
          busy <= 1'b0;
        end
      end
    end
  end

  // Window and working words carry no reset
  always_ff @(posedge clk) begin
    if (ctl.load) begin
      win <= {win[503:0], ctl.byte_val};
    end else if (busy) begin
      win <= {win[479:0], w_new};
    end
    if (ctl.start) begin
      work <= hash_in;
    end else if (busy) begin
      work <= work_next;
    end
  end

endmodule

`default_nettype wire

[rtl/sha256_stream_hasher_top.sv]
`default_nettype none

// Byte-stream SHA-256 hasher.
// Input channel (in_valid/in_ready): command plus data_byte. A data command
// appends one byte; finalize pads, compresses and returns the digest;
// restart starts a new message; command 3 is dropped.
// Output channel (out_valid/out_ready): one transaction per digest word,
// word_index 0..7 with last on word 7. A data or finalize command after
// finalize returns a single transaction with error=1, last=1, word zero.
// Sequence: the byte that fills a 64-byte block is loaded as the round
// unit starts; the single round unit then runs its rounds and the chaining
// update follows, with input held off until it is done. Finalize shifts in
// the pad byte, zero fill and the bit length, runs one compression (two when
// the length does not fit in the current block), then emits the digest
// words, waiting whenever the receiver stalls.
// in_ready is high only while the sequencer is idle and the output
// register is free or being drained this cycle; a stalled receiver holds
// the output register and the sequencer waits. Reset (synchronous, high)
// loads the initial hash values and clears length, fill and done state.
module sha256_stream_hasher_top (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [1:0]  command,
  input  wire logic [7:0]  data_byte,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [31:0]      digest_word,
  output logic [2:0]       word_index,
  output logic             last,
  output logic             error
);
  import shs_pkg::*;

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_PAD  = 3'd1;  // zero fill up to the length field
  localparam logic [2:0] S_LEN  = 3'd2;  // shift in 64-bit bit length
  localparam logic [2:0] S_COMP = 3'd3;  // wait for the round unit
  localparam logic [2:0] S_EMIT = 3'd4;  // stream out digest words

  logic [2:0]  state;
  logic [2:0]  ret_state;
  hstate_t     hash;
  logic [6:0]  fill;
  logic [60:0] byte_total;
  logic        done_flag;
  logic [63:0] len_sr;
  logic [2:0]  emit_idx;

  logic     accept;
  logic     out_free;
  logic     out_load;
  cmp_ctl_t ctl;
  hstate_t  work;
  logic     cmp_done;

  assign out_free = !out_valid || out_ready;
  assign in_ready = (state == S_IDLE) && out_free;
  assign accept   = in_valid && in_ready;

  // Output register gets a new word this cycle (error word or digest word)
  assign out_load = ((state == S_IDLE) && accept && done_flag &&
                     ((command == CMD_DATA) || (command == CMD_FINAL))) ||
                    ((state == S_EMIT) && out_free);

  // Drive the window: message bytes, pad byte, zeros, length bytes
  always_comb begin
    ctl.load     = 1'b0;
    ctl.byte_val = 8'h00;
    ctl.start    = 1'b0;
    unique case (state)
      S_IDLE: begin
        if (accept && !done_flag) begin
          if (command == CMD_DATA) begin
            ctl.load     = 1'b1;
            ctl.byte_val = data_byte;
            ctl.start    = (fill == BLK_LAST);
          end else if (command == CMD_FINAL) begin
            ctl.load     = 1'b1;
            ctl.byte_val = PAD_BYTE;
          end
        end
      end
      S_PAD: begin
        if (fill == BLK_FULL) begin
          ctl.start = 1'b1;
        end else if (fill != LEN_POS) begin
          ctl.load  = 1'b1;
          ctl.start = (fill == BLK_LAST);
        end
      end
      S_LEN: begin
        ctl.load     = 1'b1;
        ctl.byte_val = len_sr[63:56];
        ctl.start    = (fill == BLK_LAST);
      end
      S_COMP, S_EMIT: begin
        ctl.load = 1'b0;
      end
      default: begin
        ctl.load = 1'b0;
      end
    endcase
  end

  shs_compress u_compress (
    .clk     (clk),
    .rst     (rst),
    .ctl     (ctl),
    .hash_in (hash),
    .work    (work),
    .done    (cmp_done)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      ret_state  <= S_IDLE;
      fill       <= 7'd0;
      byte_total <= 61'd0;
      done_flag  <= 1'b0;
      emit_idx   <= 3'd0;
      out_valid  <= 1'b0;
      for (int i = 0; i < 8; i++) begin
        hash[i] <= IV[i];
      end
    end else begin
      if (out_valid && out_ready && !out_load) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (accept) begin
            if (command == CMD_RESTART) begin
              fill       <= 7'd0;
              byte_total <= 61'd0;
              done_flag  <= 1'b0;
              for (int i = 0; i < 8; i++) begin
                hash[i] <= IV[i];
              end
            end else if (command != CMD_NONE && done_flag) begin
              out_valid   <= 1'b1;
              digest_word <= 32'd0;
              word_index  <= 3'd0;
              last        <= 1'b1;
              error       <= 1'b1;
            end else if (command == CMD_DATA) begin
              byte_total <= byte_total + 61'd1;
              if (fill == BLK_LAST) begin
                fill      <= 7'd0;
                ret_state <= S_IDLE;
                state     <= S_COMP;
              end else begin
                fill <= fill + 7'd1;
              end
            end else if (command == CMD_FINAL) begin
              len_sr <= {byte_total, 3'b000};
              fill   <= fill + 7'd1;
              state  <= S_PAD;
            end
          end
        end
        S_PAD: begin
          if (ctl.start) begin
            fill      <= 7'd0;
            ret_state <= S_PAD;
            state     <= S_COMP;
          end else if (fill == LEN_POS) begin
            state <= S_LEN;
          end else begin
            fill <= fill + 7'd1;
          end
        end
        S_LEN: begin
          len_sr <= {len_sr[55:0], 8'h00};
          if (ctl.start) begin
            fill      <= 7'd0;
            ret_state <= S_EMIT;
            state     <= S_COMP;
          end else begin
            fill <= fill + 7'd1;
          end
        end
        S_COMP: begin
          if (cmp_done) begin
            for (int i = 0; i < 8; i++) begin
              hash[i] <= hash[i] + work[i];
            end
            state <= ret_state;
            if (ret_state == S_EMIT) begin
              done_flag <= 1'b1;
              emit_idx  <= 3'd0;
            end
          end
        end
        S_EMIT: begin
          if (out_free) begin
            out_valid   <= 1'b1;
            digest_word <= hash[emit_idx];
            word_index  <= emit_idx;
            last        <= (emit_idx == 3'd7);
            error       <= 1'b0;
            emit_idx    <= emit_idx + 3'd1;
            if (emit_idx == 3'd7) begin
              state <= S_IDLE;
            end
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  a_done_in_comp: assert property (@(posedge clk) disable iff (rst)
    cmp_done |-> state == S_COMP)
    else $error("round unit finished outside the compress wait");

  a_fill_range: assert property (@(posedge clk) disable iff (rst)
    fill <= BLK_FULL)
    else $error("fill count past a full block");

  a_error_result: assert property (@(posedge clk) disable iff (rst)
    (out_valid && error) |-> (digest_word == 32'd0 && word_index == 3'd0 && last))
    else $error("malformed error result");

  a_last_word: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !error && last) |-> word_index == 3'd7)
    else $error("last flag on a word other than the final one");

  a_done_rise: assert property (@(posedge clk) disable iff (rst)
    $rose(done_flag) |-> (state == S_EMIT && emit_idx == 3'd0))
    else $error("done flag set without a digest to emit");

endmodule

`default_nettype wire

[dv/sha256_digest_check.sv]
`timescale 1ns / 100ps

module sha256_digest_check (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        in_valid,
  input  wire logic        in_ready,
  input  wire logic [1:0]  command,
  input  wire logic [7:0]  data_byte,
  input  wire logic        out_valid,
  input  wire logic        out_ready,
  input  wire logic [31:0] digest_word,
  input  wire logic [2:0]  word_index,
  input  wire logic        last,
  input  wire logic        error,
  output int               fail_count,
  output int               pending
);
  import shs_pkg::*;

  localparam logic [7:0] PAD_MARK   = 8'h80;
  localparam int         LEN_OFFSET = 56;

  localparam logic [31:0] START_H [8] = '{
    32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
    32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19};

  localparam logic [31:0] ROUND_K [64] = '{
    32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5, 32'h3956c25b, 32'h59f111f1,
    32'h923f82a4, 32'hab1c5ed5, 32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
    32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174, 32'he49b69c1, 32'hefbe4786,
    32'h0fc19dc6, 32'h240ca1cc, 32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
    32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7, 32'hc6e00bf3, 32'hd5a79147,
    32'h06ca6351, 32'h14292967, 32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
    32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85, 32'ha2bfe8a1, 32'ha81a664b,
    32'hc24b8b70, 32'hc76c51a3, 32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
    32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5, 32'h391c0cb3, 32'h4ed8aa4a,
    32'h5b9cca4f, 32'h682e6ff3, 32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
    32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2};

  typedef struct packed {
    logic [31:0] word_val;
    logic [2:0]  word_pos;
    logic        is_last;
    logic        is_err;
  } digest_beat_t;

  // hasher state as the block should hold it
  logic [31:0] chain_h [8];
  logic [7:0]  msg_block [64];
  int unsigned fill;
  logic [60:0] total_bytes;
  bit          finished;

  digest_beat_t digest_q[$];
  digest_beat_t want;
  int           mismatches;

  function automatic logic [31:0] rotr(input logic [31:0] v, input int n);
    return (v >> n) | (v << (32 - n));
  endfunction

  function automatic void restart_state();
    for (int i = 0; i < 8; i++) chain_h[i] = START_H[i];
    for (int i = 0; i < 64; i++) msg_block[i] = 8'h00;
    fill = 0;
    total_bytes = '0;
    finished = 1'b0;
  endfunction

  // 64 rounds over msg_block, schedule kept in a 16-word ring
  function automatic void compress_block();
    logic [31:0] w [16];
    logic [31:0] s [8];
    logic [31:0] wt, x15, x2, t1, t2;
    for (int t = 0; t < 16; t++)
      w[t] = {msg_block[4*t], msg_block[4*t+1], msg_block[4*t+2], msg_block[4*t+3]};
    for (int i = 0; i < 8; i++) s[i] = chain_h[i];
    for (int t = 0; t < 64; t++) begin
      if (t < 16) begin
        wt = w[t];
      end else begin
        x15 = w[(t - 15) % 16];
        x2  = w[(t - 2) % 16];
        wt = w[t % 16] + (rotr(x15, 7) ^ rotr(x15, 18) ^ (x15 >> 3)) + w[(t - 7) % 16] +
             (rotr(x2, 17) ^ rotr(x2, 19) ^ (x2 >> 10));
        w[t % 16] = wt;
      end
      t1 = s[7] + (rotr(s[4], 6) ^ rotr(s[4], 11) ^ rotr(s[4], 25)) +
           ((s[4] & s[5]) ^ (~s[4] & s[6])) + ROUND_K[t] + wt;
      t2 = (rotr(s[0], 2) ^ rotr(s[0], 13) ^ rotr(s[0], 22)) +
           ((s[0] & s[1]) ^ (s[0] & s[2]) ^ (s[1] & s[2]));
      s[7] = s[6];
      s[6] = s[5];
      s[5] = s[4];
      s[4] = s[3] + t1;
      s[3] = s[2];
      s[2] = s[1];
      s[1] = s[0];
      s[0] = t1 + t2;
    end
    for (int i = 0; i < 8; i++) chain_h[i] = chain_h[i] + s[i];
  endfunction

  // advance the state for one accepted transaction, queue the digest words it causes
  function automatic void absorb_item(input logic [1:0] cmd, input logic [7:0] b);
    logic [63:0]  bit_len;
    digest_beat_t beat;
    if (cmd == CMD_RESTART) begin
      restart_state();
      return;
    end
    if (cmd == CMD_NONE) return;
    if (finished) begin
      beat = '{word_val: 32'd0, word_pos: 3'd0, is_last: 1'b1, is_err: 1'b1};
      digest_q = {digest_q, beat};
      return;
    end
    if (cmd == CMD_DATA) begin
      msg_block[fill] = b;
      fill++;
      total_bytes = total_bytes + 61'd1;
      if (fill == 64) begin
        compress_block();
        fill = 0;
      end
      return;
    end
    bit_len = {total_bytes, 3'b000};
    msg_block[fill] = PAD_MARK;
    fill++;
    if (fill > LEN_OFFSET) begin
      for (int i = fill; i < 64; i++) msg_block[i] = 8'h00;
      compress_block();
      fill = 0;
    end
    for (int i = fill; i < LEN_OFFSET; i++) msg_block[i] = 8'h00;
    for (int i = 0; i < 8; i++) msg_block[63 - i] = bit_len[8*i +: 8];
    compress_block();
    fill = 0;
    finished = 1'b1;
    for (int i = 0; i < 8; i++) begin
      beat = '{word_val: chain_h[i], word_pos: 3'(i), is_last: (i == 7), is_err: 1'b0};
      digest_q = {digest_q, beat};
    end
  endfunction

  always @(posedge clk) begin
    if (rst) begin
      restart_state();
      digest_q.delete();
      mismatches = 0;
    end else begin
      // outputs first: a word leaving at this edge can only belong to an older transaction
      if (out_valid && out_ready) begin
        if (digest_q.size() == 0) begin
          if (mismatches < 10)
            $display("%0t: unexpected word %h idx %0d last %b err %b", $realtime,
                     digest_word, word_index, last, error);
          mismatches++;
        end else begin
          want = digest_q.pop_front();
          if (digest_word !== want.word_val || word_index !== want.word_pos ||
              last !== want.is_last || error !== want.is_err) begin
            if (mismatches < 10)
              $display("%0t: exp word %h idx %0d last %b err %b, got %h idx %0d last %b err %b",
                       $realtime, want.word_val, want.word_pos, want.is_last, want.is_err,
                       digest_word, word_index, last, error);
            mismatches++;
          end
        end
      end
      if (in_valid && in_ready) absorb_item(command, data_byte);
    end
    fail_count <= mismatches;
    pending <= digest_q.size();
  end

endmodule

[dv/sha256_stream_hasher_top_test.sv]
`timescale 1ns / 100ps

// Stimulus and verdict for the byte-stream SHA-256 hasher. Prediction and
// comparison live in sha256_digest_check, which sits beside the block.
module sha256_stream_hasher_top_test;
  import shs_pkg::*;

  localparam int unsigned ITEM_TARGET  = 320;
  localparam int unsigned HOLD_CYCLES  = 300;  // long receiver hold-off
  localparam int unsigned DRAIN_CYCLES = 250;  // > two compressions plus padding
  localparam int unsigned CYCLE_LIMIT  = 400000;

  // message lengths that sit on the padding and block edges
  localparam int unsigned EDGE_LEN [10] = '{55, 56, 57, 63, 64, 65, 119, 120, 127, 128};

  logic        clk;
  logic        rst;
  logic        in_valid;
  logic        in_ready;
  logic [1:0]  command;
  logic [7:0]  data_byte;
  logic        out_valid;
  logic        out_ready;
  logic [31:0] digest_word;
  logic [2:0]  word_index;
  logic        last;
  logic        error;

  int          fail_count;
  int          pending;
  int unsigned items_sent;
  int unsigned cycle_count;
  bit          tx_fast;       // sender burst mode: no gaps between transactions
  bit          hold_request;  // asks the receiver for one long hold-off

  initial clk = 1'b0;
  always #5 clk = ~clk;

  sha256_stream_hasher_top dut (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .command     (command),
    .data_byte   (data_byte),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .digest_word (digest_word),
    .word_index  (word_index),
    .last        (last),
    .error       (error)
  );

  sha256_digest_check digest_check (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .command     (command),
    .data_byte   (data_byte),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .digest_word (digest_word),
    .word_index  (word_index),
    .last        (last),
    .error       (error),
    .fail_count  (fail_count),
    .pending     (pending)
  );

  // Offer one transaction after a random gap and hold it until accepted.
  // valid stays up across back-to-back transactions (gap of zero).
  task automatic send_item(input logic [1:0] cmd, input logic [7:0] b);
    int unsigned gap;
    gap = tx_fast ? 0 : $urandom_range(0, 9);
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid  <= 1'b1;
    command   <= cmd;
    data_byte <= b;
    do @(posedge clk); while (!(in_valid && in_ready));
    if (cmd != CMD_NONE) items_sent++;
  endtask

  // Stop offering and wait for every predicted digest word to come back.
  // The extra edge lets the checker's count catch up with the last transaction.
  task automatic wait_drained();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
  endtask

  // One message: optional restart, n bytes with stray no-op commands and the
  // odd mid-message restart (abandoned message), then finalize.
  task automatic send_message(input int unsigned n_bytes, input bit fresh);
    int unsigned k;
    if (fresh) send_item(CMD_RESTART, 8'($urandom));
    for (k = 0; k < n_bytes; k++) begin
      if ($urandom_range(0, 11) == 0) send_item(CMD_NONE, 8'($urandom));
      if ($urandom_range(0, 79) == 0) send_item(CMD_RESTART, 8'($urandom));
      send_item(CMD_DATA, 8'($urandom));
    end
    send_item(CMD_FINAL, 8'($urandom));
  endtask

  // Receiver: random stall before each transaction, with stretches of no stalls.
  // A hold request from the stimulus turns one stall into a long hold-off, so
  // the output register fills and the block stops taking input.
  initial begin
    int unsigned gap;
    int unsigned stretch;
    bit          rx_fast;
    out_ready <= 1'b0;
    stretch = 0;
    rx_fast = 1'b0;
    forever begin
      if (stretch == 0) begin
        stretch = $urandom_range(8, 32);
        rx_fast = ($urandom_range(0, 2) == 0);
      end
      stretch--;
      gap = rx_fast ? 0 : $urandom_range(0, 9);
      if (hold_request) begin
        hold_request = 1'b0;
        gap = HOLD_CYCLES;
      end
      if (gap != 0) begin
        out_ready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (!(out_valid && out_ready));
    end
  end

  // Watchdog: a hung handshake ends the run as a failure.
  initial begin
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("tb: failure");
    $finish;
  end

  initial begin
    int unsigned msg_len;
    hold_request = 1'b0;
    tx_fast      = 1'b0;
    items_sent   = 0;
    rst       <= 1'b1;
    in_valid  <= 1'b0;
    command   <= CMD_NONE;
    data_byte <= 8'h00;
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    // Directed: empty message straight out of reset, then items after
    // finalization (error words, no state change), a no-op command while done
    // and after a restart, short messages with extreme byte values, back-to-back
    // restarts and another empty message.
    send_item(CMD_FINAL, 8'h00);
    send_item(CMD_DATA, 8'hff);
    send_item(CMD_FINAL, 8'h00);
    send_item(CMD_NONE, 8'hff);
    send_item(CMD_DATA, 8'h00);
    send_item(CMD_RESTART, 8'h00);
    send_item(CMD_NONE, 8'h5a);
    send_item(CMD_DATA, 8'h61);
    send_item(CMD_DATA, 8'h62);
    send_item(CMD_DATA, 8'h63);
    send_item(CMD_FINAL, 8'hff);
    send_item(CMD_RESTART, 8'hff);
    send_item(CMD_DATA, 8'h00);
    send_item(CMD_DATA, 8'hff);
    send_item(CMD_FINAL, 8'h00);
    send_item(CMD_RESTART, 8'h00);
    send_item(CMD_RESTART, 8'h00);
    send_item(CMD_FINAL, 8'h00);

    // Backpressure: receiver holds off while the sender keeps offering a digest
    // plus several error transactions; then the sender waits for the drain.
    wait_drained();
    hold_request = 1'b1;
    tx_fast = 1'b1;
    send_item(CMD_RESTART, 8'h00);
    send_item(CMD_DATA, 8'h31);
    send_item(CMD_DATA, 8'h32);
    send_item(CMD_FINAL, 8'h00);
    send_item(CMD_DATA, 8'h00);
    send_item(CMD_DATA, 8'hff);
    send_item(CMD_FINAL, 8'h00);
    send_item(CMD_DATA, 8'h7e);
    wait_drained();

    // Random messages. Lengths lean on short messages and on the block and
    // padding edges (length field fits / needs a second block); sometimes no
    // restart ahead of a message or stray items after finalize, which only
    // draw error words.
    while (items_sent < ITEM_TARGET) begin
      tx_fast = ($urandom_range(0, 3) == 0);
      case ($urandom_range(0, 9))
        0, 1, 2, 3, 4: msg_len = $urandom_range(0, 8);
        5, 6, 7:       msg_len = EDGE_LEN[$urandom_range(0, 9)];
        default:       msg_len = $urandom_range(0, 140);
      endcase
      send_message(msg_len, $urandom_range(0, 6) != 0);
      if ($urandom_range(0, 3) == 0) begin
        repeat ($urandom_range(1, 2)) begin
          if ($urandom_range(0, 1) == 0) send_item(CMD_DATA, 8'($urandom));
          else send_item(CMD_FINAL, 8'($urandom));
        end
      end
      if ($urandom_range(0, 4) == 0) wait_drained();
    end

    wait_drained();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (fail_count == 0 && pending == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

[files.f]
rtl/shs_pkg.sv
rtl/shs_compress.sv
rtl/sha256_stream_hasher_top.sv
dv/sha256_digest_check.sv
dv/sha256_stream_hasher_top_test.sv
